// ----- rtl/box_points_to_detection_assert.svh -----
// ---------------------------------------------------------------------------
// Box points to detection: assertion macros
// Shared forms for the concurrent checks, clocked on clk and idle in reset.
// ---------------------------------------------------------------------------
`ifndef BOX_POINTS_TO_DETECTION_ASSERT_SVH
`define BOX_POINTS_TO_DETECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bptd_pkg.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: package
// Widths, status codes, register indexes and the types shared by the block.
// ---------------------------------------------------------------------------
package bptd_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 20;
  localparam int DIM_W      = COORD_W;
  localparam int COEF_W     = 16;
  localparam int FRAC       = COEF_W - 1;
  localparam int ROUND_C    = 2 ** (FRAC - 1);

  localparam int PROD_W = COEF_W + COORD_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = ACC_W - FRAC;
  localparam int XF_W   = SH_W + 1;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COS_YAW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIM  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM  = CFG_IDX_W'(5);

  localparam logic signed [COEF_W-1:0] COS_RESET = {1'b0, {(COEF_W-1){1'b1}}};

  localparam int RF_PRED = 0;
  localparam int RF_BAD  = 1;
  localparam int RF_MANY = 2;

  typedef enum logic [2:0] {
    ST_ACCEPTED,
    ST_PREDICTED,
    ST_BAD_POINT,
    ST_TOO_SMALL,
    ST_TOO_LARGE,
    ST_TOO_MANY
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic signed [COEF_W-1:0]  cos_yaw;
    logic signed [COEF_W-1:0]  sin_yaw;
  } xf_cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] min_dim;
    logic [DIM_W-1:0] max_dim;
  } lim_cfg_t;

  typedef struct packed {
    logic [2:0]                flags;
    logic [CNT_W-1:0]          count;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
  } rec_t;

endpackage

// ----- rtl/bptd_point_if.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: point channel
// One corner point per item, with its object-level flags.
// ---------------------------------------------------------------------------
interface bptd_point_if;
  import bptd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      point_bad;
  logic                      predicted;
  logic                      last_point;

  modport source (
    output valid, point_x, point_y, point_bad, predicted, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_bad, predicted, last_point,
    output ready
  );
endinterface

// ----- rtl/bptd_det_if.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: detection channel
// One finished detection per item.
// ---------------------------------------------------------------------------
interface bptd_det_if;
  import bptd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [DIM_W-1:0]          box_length;
  logic [DIM_W-1:0]          box_width;

  modport source (
    output valid, status, center_x, center_y, box_length, box_width,
    input  ready
  );

  modport sink (
    input  valid, status, center_x, center_y, box_length, box_width,
    output ready
  );
endinterface

// ----- rtl/bptd_front.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: front end
// Rotates and shifts each point in two stages, then folds it into the object
// extremes, sums and flags; the last point pushes the object record.
// ---------------------------------------------------------------------------
module bptd_front (
  input  logic             clk,
  input  logic             rst,
  input  bptd_pkg::xf_cfg_t xf,
  bptd_point_if.sink       points,
  output logic             push,
  output bptd_pkg::rec_t   push_data,
  input  logic             q_full
);
  import bptd_pkg::*;

  function automatic logic signed [COORD_W-1:0] shift_sat(
    input logic signed [COORD_W-1:0] off,
    input logic signed [ACC_W-1:0]   acc
  );
    logic signed [SH_W-1:0] sh;
    logic signed [XF_W-1:0] t;
    sh = SH_W'(acc >>> FRAC);
    t  = XF_W'(off) + XF_W'(sh);
    if ((&t[XF_W-1:COORD_W-1]) || !(|t[XF_W-1:COORD_W-1])) begin
      return t[COORD_W-1:0];
    end else if (t[XF_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic                      advance;
  logic                      s1_valid, s1_bad, s1_pred, s1_last;
  logic signed [PROD_W-1:0]  p_cx, p_sy, p_sx, p_cy;
  logic                      s2_valid, s2_bad, s2_pred, s2_last;
  logic signed [COORD_W-1:0] s2_x, s2_y;
  logic signed [ACC_W-1:0]   acc_x, acc_y;
  rec_t                      acc, acc_next;

  assign advance       = !(s2_valid && s2_last && q_full);
  assign points.ready  = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_bad  <= points.point_bad;
      s1_pred <= points.predicted;
      s1_last <= points.last_point;
      p_cx    <= PROD_W'(xf.cos_yaw * points.point_x);
      p_sy    <= PROD_W'(xf.sin_yaw * points.point_y);
      p_sx    <= PROD_W'(xf.sin_yaw * points.point_x);
      p_cy    <= PROD_W'(xf.cos_yaw * points.point_y);
    end
  end

  assign acc_x = ACC_W'(p_cx) - ACC_W'(p_sy) + ACC_W'(ROUND_C);
  assign acc_y = ACC_W'(p_sx) + ACC_W'(p_cy) + ACC_W'(ROUND_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_bad  <= s1_bad;
      s2_pred <= s1_pred;
      s2_last <= s1_last;
      s2_x    <= shift_sat(xf.offset_x, acc_x);
      s2_y    <= shift_sat(xf.offset_y, acc_y);
    end
  end

  always_comb begin
    acc_next = acc;
    if (s2_pred) begin
      acc_next.flags[RF_PRED] = 1'b1;
    end
    if (s2_bad) begin
      acc_next.flags[RF_BAD] = 1'b1;
    end else if (acc.count >= CNT_W'(MAX_POINTS)) begin
      acc_next.flags[RF_MANY] = 1'b1;
    end else begin
      if (acc.count == '0) begin
        acc_next.min_x = s2_x;
        acc_next.max_x = s2_x;
        acc_next.min_y = s2_y;
        acc_next.max_y = s2_y;
      end else begin
        if (s2_x < acc.min_x) acc_next.min_x = s2_x;
        if (s2_x > acc.max_x) acc_next.max_x = s2_x;
        if (s2_y < acc.min_y) acc_next.min_y = s2_y;
        if (s2_y > acc.max_y) acc_next.max_y = s2_y;
      end
      acc_next.sum_x = acc.sum_x + SUM_W'(s2_x);
      acc_next.sum_y = acc.sum_y + SUM_W'(s2_y);
      acc_next.count = acc.count + CNT_W'(1);
    end
  end

  assign push      = s2_valid && s2_last && !q_full;
  assign push_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid && advance) begin
      acc <= s2_last ? '0 : acc_next;
    end
  end
endmodule

// ----- rtl/bptd_queue.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: object queue
// A short first-in first-out store of finished object records.
// ---------------------------------------------------------------------------
module bptd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bptd_pkg::rec_t push_data,
  output logic           full,
  input  logic           pop,
  output bptd_pkg::rec_t head,
  output logic           empty
);
  import bptd_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end
endmodule

// ----- rtl/bptd_back.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: back end
// Grades each object record, divides the sums of an accepted record by the
// point count one bit a cycle, and holds the detection in an output register.
// ---------------------------------------------------------------------------
module bptd_back (
  input  logic              clk,
  input  logic              rst,
  input  bptd_pkg::lim_cfg_t lim,
  input  logic              q_empty,
  input  bptd_pkg::rec_t    head,
  output logic              pop,
  bptd_det_if.source        dets
);
  import bptd_pkg::*;

  function automatic logic [CNT_W+SUM_W-1:0] div_step(
    input logic [CNT_W-1:0] rem,
    input logic [SUM_W-1:0] dq,
    input logic [CNT_W-1:0] d
  );
    logic [CNT_W:0] t;
    logic           q;
    t = {rem, dq[SUM_W-1]};
    q = (t >= {1'b0, d});
    if (q) begin
      t = t - {1'b0, d};
    end
    return {t[CNT_W-1:0], dq[SUM_W-2:0], q};
  endfunction

  back_state_t       state, state_next;
  status_t           status_c, status_r, out_status;
  logic [DIM_W-1:0]  len_c, wid_c, len_r, wid_r;
  logic [CNT_W-1:0]  divisor, rem_x, rem_y;
  logic [SUM_W-1:0]  dq_x, dq_y, q_x, q_y;
  logic              neg_x, neg_y;
  logic [STEP_W-1:0] step;
  logic              div_en, emit, slot_free;
  logic              out_valid;
  logic signed [COORD_W-1:0] out_cx, out_cy;
  logic [DIM_W-1:0]  out_len, out_wid;

  assign len_c = head.max_x - head.min_x;
  assign wid_c = head.max_y - head.min_y;

  always_comb begin
    if (head.flags[RF_PRED]) begin
      status_c = ST_PREDICTED;
    end else if (head.flags[RF_BAD]) begin
      status_c = ST_BAD_POINT;
    end else if (head.flags[RF_MANY]) begin
      status_c = ST_TOO_MANY;
    end else if (head.count == '0) begin
      status_c = ST_BAD_POINT;
    end else if (len_c < lim.min_dim || wid_c < lim.min_dim) begin
      status_c = ST_TOO_SMALL;
    end else if (len_c > lim.max_dim || wid_c > lim.max_dim) begin
      status_c = ST_TOO_LARGE;
    end else begin
      status_c = ST_ACCEPTED;
    end
  end

  assign slot_free = !out_valid || dets.ready;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (status_c == ST_ACCEPTED) ? B_DIV : B_EMIT;
        end
      end
      B_DIV: begin
        if (step == STEP_W'(SUM_W - 1)) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    div_en = 1'b0;
    emit   = 1'b0;
    case (state)
      B_IDLE:  pop    = !q_empty;
      B_DIV:   div_en = 1'b1;
      B_EMIT:  emit   = slot_free;
      default: pop    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_c;
      len_r    <= (status_c == ST_ACCEPTED) ? len_c : '0;
      wid_r    <= (status_c == ST_ACCEPTED) ? wid_c : '0;
      neg_x    <= head.sum_x[SUM_W-1];
      neg_y    <= head.sum_y[SUM_W-1];
      dq_x     <= head.sum_x[SUM_W-1] ? SUM_W'(-head.sum_x) : SUM_W'(head.sum_x);
      dq_y     <= head.sum_y[SUM_W-1] ? SUM_W'(-head.sum_y) : SUM_W'(head.sum_y);
      rem_x    <= '0;
      rem_y    <= '0;
      divisor  <= head.count;
      step     <= '0;
    end else if (div_en) begin
      {rem_x, dq_x} <= div_step(rem_x, dq_x, divisor);
      {rem_y, dq_y} <= div_step(rem_y, dq_y, divisor);
      step          <= step + STEP_W'(1);
    end
  end

  assign q_x = neg_x ? (~dq_x + SUM_W'(1)) : dq_x;
  assign q_y = neg_y ? (~dq_y + SUM_W'(1)) : dq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dets.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= status_r;
      out_cx     <= (status_r == ST_ACCEPTED) ? q_x[COORD_W-1:0] : '0;
      out_cy     <= (status_r == ST_ACCEPTED) ? q_y[COORD_W-1:0] : '0;
      out_len    <= len_r;
      out_wid    <= wid_r;
    end
  end

  assign dets.valid      = out_valid;
  assign dets.status     = out_status;
  assign dets.center_x   = out_cx;
  assign dets.center_y   = out_cy;
  assign dets.box_length = out_len;
  assign dets.box_width  = out_wid;
endmodule

// ----- rtl/box_points_to_detection.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: top level
// Turns the corner points of one object into a vehicle-frame detection.
// ---------------------------------------------------------------------------
// Channel   Dir  Item
// points    in   one corner point with bad, predicted and last flags
// dets      out  status, centroid, length and width of one object
// cfg_*     in   register write: index 0..5, data 20 bits
//
// The front end takes one point per cycle through its transform stages, but
// stalls while a finished object meets a full queue. The back end pops each
// object and emits it, passing an accepted one through the bit-serial centroid
// divider. A two-entry object queue lets points flow while the back end divides.
// Reset is synchronous; no clearing pass is needed after it.
// ---------------------------------------------------------------------------
module box_points_to_detection (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bptd_pkg::CFG_DATA_W-1:0]  cfg_data,
  bptd_point_if.sink                       points,
  bptd_det_if.source                       dets
);
  import bptd_pkg::*;

  xf_cfg_t  xf;
  lim_cfg_t lim;
  logic     push, pop, q_full, q_empty;
  rec_t     push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      xf.offset_x <= '0;
      xf.offset_y <= '0;
      xf.cos_yaw  <= COS_RESET;
      xf.sin_yaw  <= '0;
      lim.min_dim <= '0;
      lim.max_dim <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: xf.offset_x <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y: xf.offset_y <= cfg_data[COORD_W-1:0];
        REG_COS_YAW:  xf.cos_yaw  <= cfg_data[COEF_W-1:0];
        REG_SIN_YAW:  xf.sin_yaw  <= cfg_data[COEF_W-1:0];
        REG_MIN_DIM:  lim.min_dim <= cfg_data[DIM_W-1:0];
        REG_MAX_DIM:  lim.max_dim <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  bptd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .xf        (xf),
    .points    (points),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  bptd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  bptd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .lim     (lim),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .dets    (dets)
  );
endmodule

// ----- rtl/bptd_checker.sv -----
// ---------------------------------------------------------------------------
// Box points to detection: port checker
// Watches the top-level ports for result ordering and payload rules.
// ---------------------------------------------------------------------------
`include "box_points_to_detection_assert.svh"

module bptd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      status,
  input logic [bptd_pkg::COORD_W-1:0]    center_x,
  input logic [bptd_pkg::COORD_W-1:0]    center_y,
  input logic [bptd_pkg::DIM_W-1:0]      box_length,
  input logic [bptd_pkg::DIM_W-1:0]      box_width
);
  import bptd_pkg::*;

  logic [3:0] pending, pending_next;
  logic       last_in, item_out;

  assign last_in  = in_valid && in_ready && in_last;
  assign item_out = out_valid && out_ready;

  always_comb begin
    pending_next = pending;
    if (last_in && !item_out) begin
      pending_next = pending + 4'd1;
    end else if (item_out && !last_in) begin
      pending_next = pending - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  `BPTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(center_x) && $stable(center_y) && $stable(box_length) && $stable(box_width), "detection changed while stalled")

  `BPTD_ASSERT_NOW(a_reject_zero, out_valid && status != ST_ACCEPTED, center_x == '0 && center_y == '0 && box_length == '0 && box_width == '0, "rejected detection carries a payload")

  `BPTD_ASSERT_NOW(a_no_orphan, out_valid, pending != '0, "detection without a finished object")
endmodule

bind box_points_to_detection bptd_checker u_bptd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (points.valid),
  .in_ready   (points.ready),
  .in_last    (points.last_point),
  .out_valid  (dets.valid),
  .out_ready  (dets.ready),
  .status     (dets.status),
  .center_x   (dets.center_x),
  .center_y   (dets.center_y),
  .box_length (dets.box_length),
  .box_width  (dets.box_width)
);

// ----- tb/tb_box_points_to_detection.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Box points to detection: testbench
// Sends objects of corner points through the block under several register
// settings and idle patterns. A scoreboard predicts each detection from the
// accepted points and checks every result field by field, in order.
// ---------------------------------------------------------------------------
module tb_box_points_to_detection;
  import bptd_pkg::*;

  localparam longint COORD_HI      = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO      = -COORD_HI - 1;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     PHASE_ITEMS   = 265;
  localparam int     HOLD_CYCLES   = 500;
  localparam int     PRINT_LIMIT   = 200;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      bad;
    logic                      pred;
    logic                      last;
  } point_t;

  typedef struct packed {
    status_t                   status;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [DIM_W-1:0]          box_length;
    logic [DIM_W-1:0]          box_width;
  } det_t;

  typedef enum {OBJ_CLEAN, OBJ_PRED, OBJ_BAD, OBJ_MANY, OBJ_WIDE} obj_kind_t;

  typedef int reg_values_t [6];

  class detection_scoreboard;
    longint off_x, off_y, cos_c, sin_c, dim_lo, dim_hi;
    longint lo_x, hi_x, lo_y, hi_y, sum_x, sum_y;
    int n_pts;
    logic [2:0] flags;
    det_t pending_dets[$];
    int errors;
    int checked;

    function new();
      off_x  = 0;
      off_y  = 0;
      cos_c  = longint'(COS_RESET);
      sin_c  = 0;
      dim_lo = 0;
      dim_hi = (longint'(1) << DIM_W) - 1;
      errors = 0;
      checked = 0;
      clear_object();
    endfunction

    function void clear_object();
      lo_x = 0;
      hi_x = 0;
      lo_y = 0;
      hi_y = 0;
      sum_x = 0;
      sum_y = 0;
      n_pts = 0;
      flags = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OFFSET_X: off_x = longint'($signed(data[COORD_W-1:0]));
        REG_OFFSET_Y: off_y = longint'($signed(data[COORD_W-1:0]));
        REG_COS_YAW:  cos_c = longint'($signed(data[COEF_W-1:0]));
        REG_SIN_YAW:  sin_c = longint'($signed(data[COEF_W-1:0]));
        REG_MIN_DIM:  dim_lo = longint'(data[DIM_W-1:0]);
        REG_MAX_DIM:  dim_hi = longint'(data[DIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint rotate(longint off, longint a, longint p, longint b, longint q);
      longint acc;
      acc = ((a * p + b * q + 16384) >>> 15) + off;
      if (acc > COORD_HI) return COORD_HI;
      if (acc < COORD_LO) return COORD_LO;
      return acc;
    endfunction

    function int pending();
      return pending_dets.size();
    endfunction

    function void take_point(point_t p);
      longint vx, vy, len, wid;
      det_t want;
      if (p.pred) flags[RF_PRED] = 1'b1;
      if (p.bad) begin
        flags[RF_BAD] = 1'b1;
      end else if (n_pts >= MAX_POINTS) begin
        flags[RF_MANY] = 1'b1;
      end else begin
        vx = rotate(off_x, cos_c, longint'(p.x), -sin_c, longint'(p.y));
        vy = rotate(off_y, sin_c, longint'(p.x), cos_c, longint'(p.y));
        if (n_pts == 0) begin
          lo_x = vx;
          hi_x = vx;
          lo_y = vy;
          hi_y = vy;
        end else begin
          if (vx < lo_x) lo_x = vx;
          if (vx > hi_x) hi_x = vx;
          if (vy < lo_y) lo_y = vy;
          if (vy > hi_y) hi_y = vy;
        end
        sum_x += vx;
        sum_y += vy;
        n_pts++;
      end
      if (!p.last) return;
      want = '0;
      len = hi_x - lo_x;
      wid = hi_y - lo_y;
      if (flags[RF_PRED]) begin
        want.status = ST_PREDICTED;
      end else if (flags[RF_BAD] || n_pts == 0) begin
        want.status = ST_BAD_POINT;
      end else if (flags[RF_MANY]) begin
        want.status = ST_TOO_MANY;
      end else if (len < dim_lo || wid < dim_lo) begin
        want.status = ST_TOO_SMALL;
      end else if (len > dim_hi || wid > dim_hi) begin
        want.status = ST_TOO_LARGE;
      end else begin
        want.status     = ST_ACCEPTED;
        want.center_x   = COORD_W'(sum_x / longint'(n_pts));
        want.center_y   = COORD_W'(sum_y / longint'(n_pts));
        want.box_length = DIM_W'(len);
        want.box_width  = DIM_W'(wid);
      end
      pending_dets.insert(pending_dets.size(), want);
      clear_object();
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_detection(det_t got);
      det_t want;
      if (pending_dets.size() == 0) begin
        report($sformatf("detection with no object pending, status %0d", got.status));
        return;
      end
      want = pending_dets[0];
      pending_dets.delete(0);
      checked++;
      if (got.status !== want.status)
        report($sformatf("detection %0d status: got %0d, want %0d",
                         checked, got.status, want.status));
      if (got.center_x !== want.center_x)
        report($sformatf("detection %0d center_x: got %0d, want %0d",
                         checked, got.center_x, want.center_x));
      if (got.center_y !== want.center_y)
        report($sformatf("detection %0d center_y: got %0d, want %0d",
                         checked, got.center_y, want.center_y));
      if (got.box_length !== want.box_length)
        report($sformatf("detection %0d box_length: got %0d, want %0d",
                         checked, got.box_length, want.box_length));
      if (got.box_width !== want.box_width)
        report($sformatf("detection %0d box_width: got %0d, want %0d",
                         checked, got.box_width, want.box_width));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bptd_point_if points();
  bptd_det_if   dets();

  box_points_to_detection u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (points),
    .dets      (dets)
  );

  detection_scoreboard board;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    det_t got;
    dets.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dets.valid && dets.ready) begin
        got.status     = status_t'(dets.status);
        got.center_x   = dets.center_x;
        got.center_y   = dets.center_y;
        got.box_length = dets.box_length;
        got.box_width  = dets.box_width;
        board.check_detection(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dets.ready <= 1'b0;
      end else begin
        dets.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic point_t make_point(longint x, longint y, bit bad, bit pred, bit last);
    point_t p;
    p.x    = x[COORD_W-1:0];
    p.y    = y[COORD_W-1:0];
    p.bad  = bad;
    p.pred = pred;
    p.last = last;
    return p;
  endfunction

  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid <= 1'b0;
      @(posedge clk);
    end
    points.valid      <= 1'b1;
    points.point_x    <= p.x;
    points.point_y    <= p.y;
    points.point_bad  <= p.bad;
    points.predicted  <= p.pred;
    points.last_point <= p.last;
    do @(posedge clk); while (!points.ready);
    board.take_point(p);
  endtask

  task automatic drain_dets();
    int waited;
    waited = 0;
    points.valid <= 1'b0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (board.pending() != 0) begin
      board.report($sformatf("%0d detections never arrived", board.pending()));
      board.pending_dets.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input reg_values_t vals, input int s_idle, input int r_idle,
                           input bit hold);
    logic [CFG_IDX_W-1:0] reg_order [6];
    int sent, n, pick, bad_at, pred_at, half, dx, dy;
    logic signed [COORD_W-1:0] cx, cy;
    obj_kind_t kind;
    bit held, bad;
    reg_order = '{REG_OFFSET_X, REG_OFFSET_Y, REG_COS_YAW, REG_SIN_YAW,
                  REG_MIN_DIM, REG_MAX_DIM};
    drain_dets();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      board.set_reg(reg_order[i], CFG_DATA_W'(vals[i]));
    end
    cfg_we <= 1'b0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    held = 1'b0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 64) kind = OBJ_CLEAN;
      else if (pick < 73) kind = OBJ_PRED;
      else if (pick < 82) kind = OBJ_BAD;
      else if (pick < 90) kind = OBJ_MANY;
      else kind = OBJ_WIDE;
      n = ($urandom_range(3) == 0) ? 1 : $urandom_range(MAX_POINTS, 2);
      if (kind == OBJ_MANY) n = $urandom_range(MAX_POINTS + 6, MAX_POINTS + 1);
      bad_at  = (kind == OBJ_BAD) ? $urandom_range(n - 1) : -1;
      pred_at = (kind == OBJ_PRED) ? $urandom_range(n - 1) : -1;
      half = 1 << $urandom_range(18);
      cx = COORD_W'($urandom);
      cy = COORD_W'($urandom);
      for (int i = 0; i < n; i++) begin
        dx  = int'($urandom_range(2 * half)) - half;
        dy  = int'($urandom_range(2 * half)) - half;
        bad = (i == bad_at) || (kind == OBJ_BAD && $urandom_range(7) == 0);
        if (kind == OBJ_WIDE)
          send_point(make_point($urandom, $urandom, 1'b0, 1'b0, i == n - 1));
        else
          send_point(make_point(cx + dx, cy + dy, bad, i == pred_at, i == n - 1));
        sent++;
        if (hold && !held && sent >= PHASE_ITEMS / 2) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
      end
    end
  endtask

  initial begin
    reg_values_t setting;
    board = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_OFFSET_X;
    cfg_data          <= '0;
    points.valid      <= 1'b0;
    points.point_x    <= '0;
    points.point_y    <= '0;
    points.point_bad  <= 1'b0;
    points.predicted  <= 1'b0;
    points.last_point <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed objects under the reset register values.
    send_point(make_point(COORD_HI, COORD_HI, 1'b0, 1'b0, 1'b1));
    send_point(make_point(COORD_LO, COORD_LO, 1'b0, 1'b0, 1'b1));
    send_point(make_point(COORD_HI, COORD_LO, 1'b0, 1'b0, 1'b0));
    send_point(make_point(COORD_LO, COORD_HI, 1'b0, 1'b0, 1'b1));
    send_point(make_point(0, 0, 1'b0, 1'b1, 1'b1));
    send_point(make_point(COORD_LO, COORD_HI, 1'b1, 1'b0, 1'b1));
    send_point(make_point(1, 2, 1'b1, 1'b0, 1'b0));
    send_point(make_point(3, 4, 1'b0, 1'b0, 1'b1));
    for (int i = 0; i <= MAX_POINTS; i++)
      send_point(make_point($urandom, $urandom, 1'b0, 1'b0, i == MAX_POINTS));

    setting = '{int'($urandom_range(1048575)) - 524288, int'($urandom_range(1048575)) - 524288,
                int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                0, 1048575};
    run_phase(setting, 37, 63, 1'b1);
    run_phase('{524287, -524288, -32768, 32767, 0, 0}, 37, 63, 1'b0);
    run_phase('{-524288, 524287, 32767, -32768, 1048575, 1048575}, 63, 37, 1'b0);
    setting = '{int'($urandom_range(1048575)) - 524288, int'($urandom_range(1048575)) - 524288,
                int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                2000 + int'($urandom_range(3000)), int'($urandom_range(1999))};
    run_phase(setting, 63, 37, 1'b0);
    setting = '{int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                int'($urandom_range(4096)), 4096 + int'($urandom_range(61440))};
    run_phase(setting, 0, 0, 1'b1);
    run_phase('{0, 0, 32767, 0, 0, 1048575}, 0, 0, 1'b0);
    drain_dets();

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
